// File: rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// ASCII frame receiver package
// Shared types, character codes and defaults for the frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 80;

   // Character codes that steer the parser
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_ADDR   = 3'd1,
      PH_SENDER = 3'd2,
      PH_TYPE   = 3'd3,
      PH_MSG    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] msg_byte;
      logic [6:0] msg_index;
      logic       frame_done;
      logic [7:0] frame_sender;
      logic [7:0] frame_type;
      logic [6:0] frame_length;
      logic       frame_too_long;
      logic       frame_aborted;
   } rsp_payload_type;

endpackage

// File: rtl/afr_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one received byte per transfer.
// ----------------------------------------------------------------------------
interface afr_req_if;
   import afr_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/afr_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one parser result per transfer.
// ----------------------------------------------------------------------------
interface afr_rsp_if;
   import afr_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ascii_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// ASCII frame receiver
// Recognizes '$' addr sender type payload '*' frames in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  : one received byte per transfer (valid/ready).
//   rsp_chan  : exactly one result per accepted byte, in order. A result
//               flags a payload byte with its index, a completed frame, an
//               overlong frame that was dropped, or a frame aborted by CR/LF;
//               sender, type and length are reported on every result.
//   csr_wr_en / csr_wr_data : write the device address (idle only).
// A result is registered; it shows on rsp_chan in the cycle after its byte.
// Throughput: one byte per clock unless stalled; the parser step is one short
//   combinational pass between the state registers and the result register.
// Reset (synchronous, active high): parser returns to waiting for '$',
//   count and latched bytes clear, device address clears to zero, the
//   result register empties and req_chan.ready is held low.
// Stall: when rsp_chan is not ready the result register holds its transfer;
//   req_chan.ready drops so no byte is taken until the result drains. A new
//   byte is taken in the same cycle that the pending result transfers.
// ----------------------------------------------------------------------------
module ascii_frame_receiver_unit #(
   parameter int MaxPayload = afr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   afr_req_if.sink    req_chan,
   afr_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import afr_pkg::*;

   logic [7:0]      dev_addr_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type result;
   logic            req_take;

   // Take a byte when the result register is empty or drains this cycle
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take       = req_chan.valid && req_chan.ready;

   // Device address register
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= '0;
      end else if (csr_wr_en) begin
         dev_addr_ff <= csr_wr_data;
      end
   end

   afr_parser #(
      .MaxPayload (MaxPayload)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (req_take),
      .rx_byte        (req_chan.data.rx_byte),
      .device_address (dev_addr_ff),
      .result         (result)
   );

   // Result register: load on a byte transfer, hold while stalled
   always_comb begin
      rsp_valid_in = req_take || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // A taken byte always leaves a result behind it
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("byte transfer produced no result");

   // A result carries at most one event
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.byte_valid, rsp_data_ff.frame_done,
                                 rsp_data_ff.frame_too_long, rsp_data_ff.frame_aborted}))
      else $error("result carries more than one event");

   // A payload byte advances the length to one past its index
   a_index_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.byte_valid) |->
         (7'(rsp_data_ff.msg_index + 7'd1) == rsp_data_ff.frame_length))
      else $error("payload index and frame length disagree");

   // Nothing is taken while a stalled result is pending
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_take)
      else $error("byte taken over a pending result");

endmodule

// File: rtl/afr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Holds the parse phase, payload count and latched header bytes; computes
// the result for the current byte and advances state when a byte is taken.
// ----------------------------------------------------------------------------
module afr_parser #(
   parameter int MaxPayload = afr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   input  logic [7:0]               device_address,
   output afr_pkg::rsp_payload_type result
);
   import afr_pkg::*;

   localparam int CntW = $clog2(MaxPayload + 1);

   phase_type         phase_ff, phase_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [7:0]        sender_ff, sender_in;
   logic [7:0]        type_ff, type_in;
   logic [CntW+6:0]   count_wide, index_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         count_ff  <= '0;
         sender_ff <= '0;
         type_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         sender_ff <= sender_in;
         type_ff   <= type_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sender_in = sender_ff;
      type_in   = type_ff;
      result    = '0;

      if (rx_byte == CHAR_DOLLAR) begin
         phase_in = PH_ADDR;
      end else if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
         result.frame_aborted = (phase_ff != PH_START);
         phase_in = PH_START;
      end else begin
         case (phase_ff)
            PH_ADDR: begin
               phase_in = (rx_byte == device_address) ? PH_SENDER : PH_START;
            end
            PH_SENDER: begin
               sender_in = rx_byte;
               phase_in  = PH_TYPE;
            end
            PH_TYPE: begin
               type_in  = rx_byte;
               count_in = '0;
               phase_in = PH_MSG;
            end
            PH_MSG: begin
               if (rx_byte == CHAR_STAR) begin
                  result.frame_done = 1'b1;
                  phase_in = PH_START;
               end else if (count_ff >= CntW'(MaxPayload)) begin
                  result.frame_too_long = 1'b1;
                  phase_in = PH_START;
               end else begin
                  result.byte_valid = 1'b1;
                  result.msg_byte   = rx_byte;
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end

      // Report counts modulo 128
      index_wide = {7'd0, count_ff};
      count_wide = {7'd0, count_in};
      if (result.byte_valid) begin
         result.msg_index = index_wide[6:0];
      end
      result.frame_sender = sender_in;
      result.frame_type   = type_in;
      result.frame_length = count_wide[6:0];
   end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// ASCII frame receiver testbench
// Drives a byte stream into the frame receiver over its request channel and
// checks every result against an in-bench parser model. Directed frames
// cover the control characters and the payload limit. A long response stall
// backs the block up. Random frames with noise then run under three idling
// mixes and several device addresses.
// ----------------------------------------------------------------------------
module testbench;
   import afr_pkg::*;

   // Generous cycle budget.
   localparam int CYCLE_LIMIT = 150000;
   localparam int RSP_HOLD_CYCLES = 160;

   // Ways to close a generated frame
   localparam int END_STAR  = 0;
   localparam int END_BREAK = 1;
   localparam int END_NONE  = 2;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   afr_req_if req_chan ();
   afr_rsp_if rsp_chan ();

   ascii_frame_receiver_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Parser model state, mirrors the block after reset
   phase_type  model_phase   = PH_START;
   logic [7:0] model_count   = '0;
   logic [7:0] model_sender  = '0;
   logic [7:0] model_kind    = '0;
   logic [7:0] model_address = '0;

   rsp_payload_type pending_results[$];
   rsp_payload_type oldest_result;

   int          mismatch_count = 0;
   int unsigned items_sent     = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned rsp_idle_pct   = 0;
   logic        rsp_hold       = 1'b0;
   event        rsp_hold_start;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the model by one received byte and return the result it causes.
   function automatic rsp_payload_type next_parse_result(input logic [7:0] c);
      rsp_payload_type r;
      r = '0;
      if (c == CHAR_DOLLAR) begin
         // restart from the address byte, keep count and latched bytes
         model_phase = PH_ADDR;
      end else if (c == CHAR_CR || c == CHAR_LF) begin
         // only a frame in progress counts as aborted
         r.frame_aborted = (model_phase != PH_START);
         model_phase = PH_START;
      end else begin
         case (model_phase)
            PH_ADDR: begin
               model_phase = (c == model_address) ? PH_SENDER : PH_START;
            end
            PH_SENDER: begin
               model_sender = c;
               model_phase = PH_TYPE;
            end
            PH_TYPE: begin
               model_kind = c;
               model_count = '0;
               model_phase = PH_MSG;
            end
            PH_MSG: begin
               if (c == CHAR_STAR) begin
                  r.frame_done = 1'b1;
                  model_phase = PH_START;
               end else if (model_count >= 8'(MAX_PAYLOAD_DEFAULT)) begin
                  // drop the byte past the limit along with the frame
                  r.frame_too_long = 1'b1;
                  model_phase = PH_START;
               end else begin
                  r.byte_valid = 1'b1;
                  r.msg_byte = c;
                  r.msg_index = model_count[6:0];
                  model_count = model_count + 8'd1;
               end
            end
            default: begin
               // outside a frame a star or any other byte is ignored
               model_phase = PH_START;
            end
         endcase
      end
      r.frame_sender = model_sender;
      r.frame_type = model_kind;
      r.frame_length = model_count[6:0];
      return r;
   endfunction

   // Offer one byte, hold it until the transfer, then record its result.
   task automatic send_byte(input logic [7:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data.rx_byte <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.push_back(next_parse_result(value));
      items_sent++;
   endtask

   // Drop valid and wait until every result has come back.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_device_address(input logic [7:0] addr);
      wait_for_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= addr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_address = addr;
   endtask

   // Mostly plain data; now and then a control character slips through.
   function automatic logic [7:0] random_body_byte();
      logic [7:0] b;
      b = 8'($urandom);
      while ((b == CHAR_DOLLAR || b == CHAR_CR || b == CHAR_LF || b == CHAR_STAR)
             && $urandom_range(99) >= 3)
         b = 8'($urandom);
      return b;
   endfunction

   task automatic send_frame(input logic [7:0] addr, input int unsigned payload_len,
                             input int ending);
      send_byte(CHAR_DOLLAR);
      send_byte(addr);
      send_byte(random_body_byte());
      send_byte(random_body_byte());
      repeat (payload_len) send_byte(random_body_byte());
      case (ending)
         END_STAR:  send_byte(CHAR_STAR);
         END_BREAK: send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
         default:   ;
      endcase
   endtask

   // --- Directed tests -------------------------------------------------------

   // Run a full frame against the reset address, with extreme field bytes.
   task automatic test_reset_address_frame();
      send_byte(CHAR_DOLLAR);
      send_byte(8'h00);          // matches the address after reset
      send_byte(8'hFF);          // sender
      send_byte(8'h00);          // frame type
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CHAR_STAR);
      wait_for_drain();
   endtask

   task automatic test_control_characters();
      set_device_address(8'h5A);
      send_byte(CHAR_STAR);      // star outside a frame is an ordinary byte
      send_byte(CHAR_CR);        // CR while waiting: no abort flag
      send_byte(CHAR_DOLLAR);
      send_byte(8'h5A);
      send_byte(8'h53);
      send_byte(CHAR_DOLLAR);    // restart from the type phase
      send_byte(8'h5A);
      send_byte(8'h53);
      send_byte(8'h54);
      send_byte(8'h70);
      send_byte(CHAR_DOLLAR);    // restart from the payload
      send_byte(8'h5A);
      send_byte(8'h73);
      send_byte(8'h74);
      send_byte(8'h71);
      send_byte(CHAR_LF);        // LF mid-payload aborts the frame
      send_byte(CHAR_DOLLAR);
      send_byte(8'h11);          // wrong address: rest of frame ignored
      send_byte(8'h78);
      send_byte(CHAR_STAR);
      send_byte(CHAR_CR);
      wait_for_drain();
   endtask

   // Fill the payload to the limit, once closed by a star, once overrun.
   task automatic test_payload_limit();
      set_device_address(8'h80);
      send_frame(8'h80, MAX_PAYLOAD_DEFAULT, END_STAR);
      send_frame(8'h80, MAX_PAYLOAD_DEFAULT + 1, END_NONE);
      send_byte(CHAR_STAR);      // after the drop this star is ignored
      wait_for_drain();
   endtask

   // Hold the response side off while the sender keeps offering bytes.
   task automatic test_response_stall();
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      -> rsp_hold_start;
      send_frame(8'h80, 40, END_STAR);
      wait_for_drain();
   endtask

   // --- Random traffic -------------------------------------------------------

   task automatic send_random_frame();
      int unsigned pick;
      int unsigned len;
      int          ending;
      logic [7:0]  addr;
      // precede some frames with line noise
      if ($urandom_range(99) < 12)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      addr = ($urandom_range(99) < 85) ? model_address : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 86)
         len = $urandom_range(0, 15);
      else if (pick < 93)
         len = $urandom_range(MAX_PAYLOAD_DEFAULT - 4, MAX_PAYLOAD_DEFAULT);
      else
         len = $urandom_range(MAX_PAYLOAD_DEFAULT + 1, MAX_PAYLOAD_DEFAULT + 4);
      pick = $urandom_range(99);
      ending = (pick < 88) ? END_STAR : (pick < 94) ? END_BREAK : END_NONE;
      send_frame(addr, len, ending);
   endtask

   task automatic test_random_traffic(input logic [7:0] addr, input int unsigned send_pct,
                                      input int unsigned recv_pct, input int unsigned count);
      int unsigned stop_at;
      set_device_address(addr);
      send_idle_pct = send_pct;
      rsp_idle_pct <= recv_pct;
      stop_at = items_sent + count;
      while (items_sent < stop_at) send_random_frame();
      wait_for_drain();
   endtask

   // --- Response side --------------------------------------------------------

   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Count the long hold-off in its own process.
   always begin
      @(rsp_hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each transfer with the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h",
                     $time, rsp_chan.data);
            mismatch_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("byte_valid", 8'(oldest_result.byte_valid),
                        8'(rsp_chan.data.byte_valid));
            check_field("msg_byte", oldest_result.msg_byte, rsp_chan.data.msg_byte);
            check_field("msg_index", 8'(oldest_result.msg_index),
                        8'(rsp_chan.data.msg_index));
            check_field("frame_done", 8'(oldest_result.frame_done),
                        8'(rsp_chan.data.frame_done));
            check_field("frame_sender", oldest_result.frame_sender,
                        rsp_chan.data.frame_sender);
            check_field("frame_type", oldest_result.frame_type, rsp_chan.data.frame_type);
            check_field("frame_length", 8'(oldest_result.frame_length),
                        8'(rsp_chan.data.frame_length));
            check_field("frame_too_long", 8'(oldest_result.frame_too_long),
                        8'(rsp_chan.data.frame_too_long));
            check_field("frame_aborted", 8'(oldest_result.frame_aborted),
                        8'(rsp_chan.data.frame_aborted));
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL ascii_frame_receiver_unit");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_address_frame();
      test_control_characters();
      test_payload_limit();
      test_response_stall();
      // sender busy and receiver lazy, then the reverse, then full rate
      test_random_traffic(8'hFF, 6, 79, 300);
      test_random_traffic(8'h00, 79, 6, 300);
      test_random_traffic(8'($urandom), 0, 0, 300);

      wait_for_drain();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASS ascii_frame_receiver_unit");
      else
         $display("FAIL ascii_frame_receiver_unit");
      $finish;
   end

endmodule
